// ----- rtl/sfhp_pkg.sv -----
// Package for the status frame hex parser.
// Holds the character constants, the hex decode function and the result type.
// No dependencies.
package sfhp_pkg;

    localparam logic [7:0] C_FRAME_OPEN  = 8'h7B;   // '{'
    localparam logic [7:0] C_FRAME_CLOSE = 8'h7D;   // '}'
    localparam logic [7:0] C_PREFIX_CHAR = 8'h34;   // '4'

    localparam int unsigned C_POS_W = 4;
    localparam logic [C_POS_W-1:0] C_PAYLOAD_MIN = 4'd12;
    localparam logic [C_POS_W-1:0] C_PREFIX_END  = 4'd2;
    localparam logic [C_POS_W-1:0] C_FLAGS_POS   = 4'd6;
    localparam logic [C_POS_W-1:0] C_BATT_POS    = 4'd8;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    typedef struct packed {
        logic        valid;
        logic [7:0]  status_flags;
        logic [15:0] battery_raw;
    } t_frame_result;

    // Non-hex characters decode to zero with ok low.
    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex       res;
        logic [7:0] diff;
        res  = '{ok: 1'b0, nib: 4'h0};
        diff = 8'h00;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff = ch - 8'h30;
            res  = '{ok: 1'b1, nib: diff[3:0]};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff = ch - 8'h57;
            res  = '{ok: 1'b1, nib: diff[3:0]};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff = ch - 8'h37;
            res  = '{ok: 1'b1, nib: diff[3:0]};
        end
        return res;
    endfunction

endpackage

// ----- rtl/sfhp_frame_parser.sv -----
// Frame parser state: tracks one open frame, checks prefix and hex digits,
// captures the status and battery nibbles. Depends on sfhp_pkg.
module sfhp_frame_parser import sfhp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    output t_frame_result o_result
);

    logic               r_in_frame,  n_in_frame;
    logic [C_POS_W-1:0] r_count,     n_count;
    logic               r_prefix_ok, n_prefix_ok;
    logic               r_digits_ok, n_digits_ok;
    logic [7:0]         r_flags,     n_flags;
    logic [15:0]        r_batt,      n_batt;
    t_hex               hex;

    assign hex = hex_decode(i_byte);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_prefix_ok = r_prefix_ok;
        n_digits_ok = r_digits_ok;
        n_flags     = r_flags;
        n_batt      = r_batt;
        o_result    = '{valid: 1'b0, status_flags: r_flags, battery_raw: r_batt};
        if (i_step) begin
            priority if (i_byte == C_FRAME_OPEN) begin
                n_in_frame  = 1'b1;
                n_count     = '0;
                n_prefix_ok = 1'b1;
                n_digits_ok = 1'b1;
                n_flags     = '0;
                n_batt      = '0;
            end else if (!r_in_frame) begin
                n_in_frame = 1'b0;
            end else if (i_byte == C_FRAME_CLOSE) begin
                n_in_frame     = 1'b0;
                o_result.valid = r_prefix_ok && r_digits_ok && (r_count >= C_PAYLOAD_MIN);
            end else begin
                // past position 11 the count stays saturated
                if (r_count < C_PAYLOAD_MIN) begin
                    n_count = r_count + 1'b1;
                    if (r_count < C_PREFIX_END) begin
                        if (i_byte != C_PREFIX_CHAR) n_prefix_ok = 1'b0;
                    end else if (r_count >= C_FLAGS_POS) begin
                        if (!hex.ok) n_digits_ok = 1'b0;
                        if (r_count < C_BATT_POS) n_flags = {r_flags[3:0], hex.nib};
                        else                      n_batt  = {r_batt[11:0], hex.nib};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_prefix_ok <= 1'b0;
            r_digits_ok <= 1'b0;
            r_flags     <= '0;
            r_batt      <= '0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_prefix_ok <= n_prefix_ok;
            r_digits_ok <= n_digits_ok;
            r_flags     <= n_flags;
            r_batt      <= n_batt;
        end
    end

endmodule

// ----- rtl/status_frame_hex_parser.sv -----
// Top level of the status frame hex parser: input register, frame parser,
// result register. Depends on sfhp_pkg and sfhp_frame_parser.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------
//  input    | i_valid / o_ready  | i_rx_byte[7:0]
//  result   | o_valid / i_ready  | o_status_flags[7:0], o_battery_raw[15:0]
//
// One item per cycle unless a pending result is stalled by i_ready low.
// The input register feeds the parser, whose result lands in the output register.
// Reset (i_rst_n low, synchronous) closes any frame and empties both registers.
// A stalled result holds the parser; o_ready stays high while the output is empty.
module status_frame_hex_parser import sfhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_status_flags,
    output logic [15:0] o_battery_raw
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_out_valid;
    logic [7:0]    r_out_flags;
    logic [15:0]   r_out_batt;
    logic          advance;
    t_frame_result result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    sfhp_frame_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (advance)      r_out_valid <= result.valid;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_rx_byte;
        if (advance && result.valid) begin
            r_out_flags <= result.status_flags;
            r_out_batt  <= result.battery_raw;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status_flags = r_out_flags;
    assign o_battery_raw  = r_out_batt;

endmodule

// ----- rtl/sfhp_checker.sv -----
// Port-level checks for the status frame hex parser, bound to the top level.
// Depends on status_frame_hex_parser.
module sfhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_status_flags,
    input logic [15:0] o_battery_raw
);

    // A stalled result keeps its fields.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status_flags) && $stable(o_battery_raw))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Right after reset the block takes input.
    a_reset_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_ready)
        else $error("not ready after reset");

    // With no pending result, nothing can hold the input side.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind status_frame_hex_parser sfhp_checker u_sfhp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status_flags (o_status_flags),
    .o_battery_raw  (o_battery_raw)
);

// ----- verif/tb_status_frame_hex_parser.sv -----
// Self-checking testbench for status_frame_hex_parser: directed frames, then random
// frame traffic with idle and stall phases, checked against a behavioral frame parser.
// Depends on sfhp_pkg and the RTL of status_frame_hex_parser.
module tb_status_frame_hex_parser import sfhp_pkg::*; ();

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;     // flags/batt below hold the expected report
        logic [7:0]  flags;
        logic [15:0] batt;
    } t_stim;

    typedef struct packed {
        logic [7:0]  flags;
        logic [15:0] batt;
    } t_frame_report;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 280;
    localparam int SEND_IDLE_PCT [4] = '{0, 62, 0, 34};
    localparam int STALL_PCT     [4] = '{0, 0, 62, 34};

    localparam t_stim DIRECTED_ROWS [22] = '{
        '{C_FRAME_CLOSE, 1'b0, 8'h00, 16'h0000},   // close brace outside a frame
        '{8'hFF,         1'b0, 8'h00, 16'h0000},   // noise outside a frame
        '{C_FRAME_OPEN,  1'b0, 8'h00, 16'h0000},
        '{8'h00,         1'b0, 8'h00, 16'h0000},   // bad prefix, abandoned below
        '{C_FRAME_OPEN,  1'b0, 8'h00, 16'h0000},   // restart inside a frame
        '{C_PREFIX_CHAR, 1'b0, 8'h00, 16'h0000},
        '{C_PREFIX_CHAR, 1'b0, 8'h00, 16'h0000},
        '{8'h00,         1'b0, 8'h00, 16'h0000},
        '{8'hFF,         1'b0, 8'h00, 16'h0000},
        '{8'h80,         1'b0, 8'h00, 16'h0000},
        '{8'h7F,         1'b0, 8'h00, 16'h0000},
        '{8'h46,         1'b0, 8'h00, 16'h0000},   // 'F'
        '{8'h66,         1'b0, 8'h00, 16'h0000},   // 'f'
        '{8'h46,         1'b0, 8'h00, 16'h0000},
        '{8'h66,         1'b0, 8'h00, 16'h0000},
        '{8'h46,         1'b0, 8'h00, 16'h0000},
        '{8'h46,         1'b0, 8'h00, 16'h0000},
        '{8'h5A,         1'b0, 8'h00, 16'h0000},   // past position 11, ignored
        '{C_FRAME_CLOSE, 1'b1, 8'hFF, 16'hFFFF},
        '{C_FRAME_OPEN,  1'b0, 8'h00, 16'h0000},   // short frame, dropped
        '{C_PREFIX_CHAR, 1'b0, 8'h00, 16'h0000},
        '{C_FRAME_CLOSE, 1'b0, 8'h00, 16'h0000}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_status_flags;
    logic [15:0] o_battery_raw;

    // behavioral parser state
    logic        in_frame;
    logic [3:0]  pay_cnt;
    logic        prefix_good;
    logic        digits_good;
    logic [7:0]  flags_acc;
    logic [15:0] batt_acc;

    t_frame_report pending_reports[$];
    t_stim         stim_q[$];
    int            mismatch_cnt;
    int            stuck_cycles;
    int            send_idle_pct;
    int            stall_pct;
    logic          hold_req;

    status_frame_hex_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status_flags (o_status_flags),
        .o_battery_raw  (o_battery_raw)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Letters share the low nibble 1..6 in both cases.
    function automatic logic [3:0] hex_nibble(input logic [7:0] ch, output logic ok);
        ok = 1'b1;
        if (ch[7:4] == 4'h3 && ch[3:0] <= 4'd9) begin
            return ch[3:0];
        end
        if ((ch[7:4] == 4'h4 || ch[7:4] == 4'h6) && ch[3:0] >= 4'd1 && ch[3:0] <= 4'd6) begin
            return ch[3:0] + 4'd9;
        end
        ok = 1'b0;
        return 4'h0;
    endfunction

    function automatic logic advance_frame_parse(input logic [7:0] ch,
                                                 output t_frame_report rpt);
        logic [3:0] nib;
        logic       ok;
        rpt = '0;
        if (ch == C_FRAME_OPEN) begin
            in_frame    = 1'b1;
            pay_cnt     = '0;
            prefix_good = 1'b1;
            digits_good = 1'b1;
            flags_acc   = '0;
            batt_acc    = '0;
        end else if (in_frame && ch == C_FRAME_CLOSE) begin
            in_frame = 1'b0;
            if (prefix_good && digits_good && pay_cnt >= C_PAYLOAD_MIN) begin
                rpt = '{flags_acc, batt_acc};
                return 1'b1;
            end
        end else if (in_frame && pay_cnt < C_PAYLOAD_MIN) begin
            if (pay_cnt < C_PREFIX_END) begin
                if (ch != C_PREFIX_CHAR) prefix_good = 1'b0;
            end else if (pay_cnt >= C_FLAGS_POS) begin
                nib = hex_nibble(ch, ok);
                if (!ok) digits_good = 1'b0;
                if (pay_cnt < C_BATT_POS) flags_acc = {flags_acc[3:0], nib};
                else                      batt_acc  = {batt_acc[11:0], nib};
            end
            pay_cnt = pay_cnt + 4'd1;
        end
        return 1'b0;
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        stim_q.push_back('{ch, 1'b0, 8'h00, 16'h0000});
    endfunction

    function automatic logic [7:0] payload_filler();
        logic [7:0] ch;
        do ch = 8'($urandom_range(255));
        while (ch == C_FRAME_OPEN || ch == C_FRAME_CLOSE);
        return ch;
    endfunction

    function automatic logic [7:0] hex_digit_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + {4'h0, nib};
        return ($urandom_range(1) ? 8'h60 : 8'h40) | {4'h0, nib - 4'd9};
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] ch;
        logic [3:0] nib;
        logic       ok;
        do begin
            ch  = payload_filler();
            nib = hex_nibble(ch, ok);
        end while (ok);
        return ch;
    endfunction

    // Mostly well-formed frames; the rest bad prefix, bad digit, short, restarted, or noise.
    task automatic queue_random_frames(input int target);
        int         frame_bytes;
        int         kind;
        int         len;
        int         bad_pos;
        int         n;
        logic [7:0] ch;
        frame_bytes = 0;
        while (frame_bytes < target) begin
            kind = $urandom_range(99);
            if (kind >= 94) begin
                n = $urandom_range(1, 6);
                repeat (n) push_char(8'($urandom_range(255)));
                frame_bytes += n;
            end else begin
                push_char(C_FRAME_OPEN);
                if (kind >= 88) begin
                    n = $urandom_range(1, 10);
                    repeat (n) push_char(payload_filler());
                    push_char(C_FRAME_OPEN);
                    frame_bytes += n + 1;
                end
                if (kind >= 82 && kind < 88)   len = $urandom_range(0, 11);
                else if ($urandom_range(9) == 0) len = $urandom_range(16, 24);
                else                             len = $urandom_range(12, 15);
                bad_pos = -1;
                if (kind >= 60 && kind < 82) begin
                    bad_pos = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(6, 11);
                end
                for (int p = 0; p < len; p++) begin
                    if (p < 2) begin
                        ch = C_PREFIX_CHAR;
                        if (p == bad_pos) begin
                            do ch = payload_filler();
                            while (ch == C_PREFIX_CHAR);
                        end
                    end else if (p >= 6 && p < 12) begin
                        ch = (p == bad_pos) ? non_hex_char()
                                            : hex_digit_char(4'($urandom_range(15)));
                    end else begin
                        ch = payload_filler();
                    end
                    push_char(ch);
                end
                push_char(C_FRAME_CLOSE);
                frame_bytes += len + 2;
            end
        end
    endtask

    // Entered and left at a falling edge; valid stays up into the next call.
    task automatic send_byte(input t_stim s);
        t_frame_report rpt;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = s.ch;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (advance_frame_parse(s.ch, rpt)) begin
            if (s.typed) rpt = '{s.flags, s.batt};
            pending_reports.push_back(rpt);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_reports();
        i_valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result: status_flags %0h battery_raw %0h",
                       o_status_flags, o_battery_raw);
                mismatch_cnt++;
            end else begin
                want = pending_reports.pop_front();
                if (o_status_flags !== want.flags) begin
                    $error("status_flags: expected %0h, got %0h", want.flags, o_status_flags);
                    mismatch_cnt++;
                end
                if (o_battery_raw !== want.batt) begin
                    $error("battery_raw: expected %0h, got %0h", want.batt, o_battery_raw);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rx_byte     = 8'h00;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        mismatch_cnt  = 0;
        stuck_cycles  = 0;
        in_frame      = 1'b0;
        pay_cnt       = '0;
        prefix_good   = 1'b0;
        digits_good   = 1'b0;
        flags_acc     = '0;
        batt_acc      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_ROWS[r]) send_byte(DIRECTED_ROWS[r]);
        drain_reports();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            stall_pct     = STALL_PCT[ph];
            // receiver holds off while bytes keep coming: fills the pipe, stalls o_ready
            if (ph == 0) hold_req = 1'b1;
            queue_random_frames(PHASE_BYTES);
            while (stim_q.size() != 0) send_byte(stim_q.pop_front());
            drain_reports();
        end

        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
